FILE: hdl/lspa_pkg.sv
// ----------------------------------------------------------------------------
// Line step pixel address: shared package
// Widths, register map and the records that travel beside the datapath.
// ----------------------------------------------------------------------------
package lspa_pkg;

   // Fixed-point length: sqrt of (dx^2 + dy^2) << 16, eight fraction bits.
   localparam int RAD_W  = 42;
   localparam int ROOT_W = 21;
   localparam int REM_W  = 23;

   // Along-line division: numerator magnitude and quotient widths.
   localparam int NUM_W = 35;
   localparam int QUO_W = 13;

   // Register map, word index into the configuration space.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_FRAME_BASE      = 2'd0;
   localparam logic [1:0] REG_BYTES_PER_ROW   = 2'd1;
   localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;

   localparam logic [14:0] BPR_RESET = 15'd4096;
   localparam logic [3:0]  BPP_RESET = 4'd4;

   // Segment data carried through the length stages.
   typedef struct packed {
      logic signed [11:0] x1;
      logic signed [11:0] y1;
      logic signed [12:0] dx;
      logic signed [12:0] dy;
      logic [12:0]        step;
      logic [31:0]        color;
   } side_type;

   // Data carried through the division stages.
   typedef struct packed {
      logic signed [11:0] x1;
      logic signed [11:0] y1;
      logic               neg_x;
      logic               neg_y;
      logic               zero_len;
      logic               valid;
      logic [31:0]        color;
   } post_type;

endpackage

FILE: hdl/lspa_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring digit-by-digit method, with stall.
// ----------------------------------------------------------------------------
module lspa_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [lspa_pkg::RAD_W-1:0]   in_radicand,
   input  lspa_pkg::side_type           in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [lspa_pkg::ROOT_W-1:0]  out_root,
   output lspa_pkg::side_type           out_side
);
   import lspa_pkg::*;

   localparam int N = ROOT_W;

   logic [N-1:0]        vld_ff;
   logic [N:0]          rdy;
   logic [REM_W-1:0]    rem_ff  [N];
   logic [ROOT_W-1:0]   root_ff [N];
   logic [RAD_W-1:0]    rad_ff  [N];
   side_type            side_ff [N];

   // A stage may load when it is empty or the stage after it moves.
   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      side_type          side_prev;
      logic              vld_prev;
      logic [REM_W:0]    rem_shift;
      logic [REM_W:0]    trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_radicand;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         rem_shift = {rem_prev[REM_W-2:0], rad_prev[RAD_W-1 -: 2]};
         trial     = {1'b0, root_prev, 2'b01};
         take      = (rem_shift >= trial);
         rem_in    = take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
         root_in   = {root_prev[ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

FILE: hdl/lspa_divider.sv
// ----------------------------------------------------------------------------
// Pipelined dual divider
// Divides two magnitudes by one shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lspa_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [lspa_pkg::NUM_W-1:0]   in_num_x,
   input  logic [lspa_pkg::NUM_W-1:0]   in_num_y,
   input  logic [lspa_pkg::ROOT_W-1:0]  in_divisor,
   input  lspa_pkg::post_type           in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [lspa_pkg::QUO_W-1:0]   out_quo_x,
   output logic [lspa_pkg::QUO_W-1:0]   out_quo_y,
   output lspa_pkg::post_type           out_side
);
   import lspa_pkg::*;

   localparam int N = QUO_W;

   logic [N-1:0]       vld_ff;
   logic [N:0]         rdy;
   logic [NUM_W-1:0]   rx_ff  [N];
   logic [NUM_W-1:0]   ry_ff  [N];
   logic [QUO_W-1:0]   qx_ff  [N];
   logic [QUO_W-1:0]   qy_ff  [N];
   logic [ROOT_W-1:0]  div_ff [N];
   post_type           side_ff [N];

   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [NUM_W-1:0]  rx_prev;
      logic [NUM_W-1:0]  ry_prev;
      logic [QUO_W-1:0]  qx_prev;
      logic [QUO_W-1:0]  qy_prev;
      logic [ROOT_W-1:0] div_prev;
      post_type          side_prev;
      logic              vld_prev;
      logic [NUM_W-1:0]  dsh;
      logic              tx;
      logic              ty;

      if (k == 0) begin : g_first
         assign rx_prev   = in_num_x;
         assign ry_prev   = in_num_y;
         assign qx_prev   = '0;
         assign qy_prev   = '0;
         assign div_prev  = in_divisor;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rx_prev   = rx_ff[k-1];
         assign ry_prev   = ry_ff[k-1];
         assign qx_prev   = qx_ff[k-1];
         assign qy_prev   = qy_ff[k-1];
         assign div_prev  = div_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // Compare against the divisor aligned to this quotient bit.
      always_comb begin
         dsh = NUM_W'(div_prev) << (N - 1 - k);
         tx  = (rx_prev >= dsh);
         ty  = (ry_prev >= dsh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rx_ff[k]   <= tx ? rx_prev - dsh : rx_prev;
            ry_ff[k]   <= ty ? ry_prev - dsh : ry_prev;
            qx_ff[k]   <= {qx_prev[QUO_W-2:0], tx};
            qy_ff[k]   <= {qy_prev[QUO_W-2:0], ty};
            div_ff[k]  <= div_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo_x = qx_ff[N-1];
   assign out_quo_y = qy_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

FILE: hdl/line_step_pixel_address_core.sv
// ----------------------------------------------------------------------------
// Line step pixel address core
// Computes the frame address of one step along a line segment.
// ----------------------------------------------------------------------------
// Each transaction carries one segment and a step index and yields one result
// transaction with the pixel's byte address, its color and the step-valid and
// write-enable flags. It takes a new transaction every cycle unless stalled;
// each passes the front stages, the 21-stage square root (one root bit per
// stage), the middle stages, the 13-stage divider (one quotient bit per stage)
// and the back stages. Result-side stalls back up through them without loss.
// Registers: frame_base at 0x0, bytes_per_row at 0x4, bytes_per_pixel at 0x8.
module line_step_pixel_address_core #(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36],
   // start_color[79:48], step_index[92:80], zero pad[95:93]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [95:0]                       req_tdata,
   // byte_address[31:0], pixel_color[63:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,
   // step_valid[0], write_enable[1]
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lspa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import lspa_pkg::*;

   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam logic signed [14:0] HALF_W = 15'(SCREEN_WIDTH / 2);
   localparam logic signed [14:0] HALF_H = 15'(SCREEN_HEIGHT / 2);
   localparam logic signed [14:0] LIM_W  = 15'(SCREEN_WIDTH);
   localparam logic signed [14:0] LIM_H  = 15'(SCREEN_HEIGHT);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [31:0] base_ff;
   logic [14:0] bpr_ff;
   logic [3:0]  bpp_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         bpr_ff  <= BPR_RESET;
         bpp_ff  <= BPP_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_FRAME_BASE:      base_ff <= csr_pwdata;
            REG_BYTES_PER_ROW:   bpr_ff  <= csr_pwdata[14:0];
            REG_BYTES_PER_PIXEL: bpp_ff  <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_FRAME_BASE:      csr_prdata = base_ff;
         REG_BYTES_PER_ROW:   csr_prdata = {17'd0, bpr_ff};
         REG_BYTES_PER_PIXEL: csr_prdata = {28'd0, bpp_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Front stages: deltas, squares, squared length
   // ------------------------------------------------------------------
   logic [2:0]           fa_vld_ff;
   logic [3:0]           fa_rdy;
   side_type             f0_side_ff, f1_side_ff, f2_side_ff;
   logic [23:0]          f1_sqx_ff, f1_sqy_ff;
   logic [24:0]          f2_sq_ff;
   side_type             req_side;
   logic                 sq_ready;

   always_comb begin
      req_side.x1    = $signed(req_tdata[11:0]);
      req_side.y1    = $signed(req_tdata[23:12]);
      req_side.dx    = $signed({req_tdata[35], req_tdata[35:24]})
                     - $signed({req_tdata[11], req_tdata[11:0]});
      req_side.dy    = $signed({req_tdata[47], req_tdata[47:36]})
                     - $signed({req_tdata[23], req_tdata[23:12]});
      req_side.color = req_tdata[79:48];
      req_side.step  = req_tdata[92:80];
   end

   always_comb begin
      fa_rdy[3] = sq_ready;
      for (int k = 2; k >= 0; k--) begin
         fa_rdy[k] = !fa_vld_ff[k] || fa_rdy[k+1];
      end
   end
   assign req_tready = fa_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_vld_ff <= '0;
      end else begin
         if (fa_rdy[0]) fa_vld_ff[0] <= req_tvalid;
         if (fa_rdy[1]) fa_vld_ff[1] <= fa_vld_ff[0];
         if (fa_rdy[2]) fa_vld_ff[2] <= fa_vld_ff[1];
      end
   end

   // Squares fit 24 bits since each delta magnitude is at most 4095.
   always_ff @(posedge clock) begin
      if (fa_rdy[0]) begin
         f0_side_ff <= req_side;
      end
      if (fa_rdy[1]) begin
         f1_side_ff <= f0_side_ff;
         f1_sqx_ff  <= 24'(f0_side_ff.dx * f0_side_ff.dx);
         f1_sqy_ff  <= 24'(f0_side_ff.dy * f0_side_ff.dy);
      end
      if (fa_rdy[2]) begin
         f2_side_ff <= f1_side_ff;
         f2_sq_ff   <= {1'b0, f1_sqx_ff} + {1'b0, f1_sqy_ff};
      end
   end

   // ------------------------------------------------------------------
   // Length: floor(256 * sqrt(dx^2 + dy^2))
   // ------------------------------------------------------------------
   logic               sr_valid;
   logic               sr_ready;
   logic [ROOT_W-1:0]  sr_root;
   side_type           sr_side;

   lspa_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fa_vld_ff[2]),
      .in_ready    (sq_ready),
      .in_radicand ({1'b0, f2_sq_ff, 16'd0}),
      .in_side     (f2_side_ff),
      .out_valid   (sr_valid),
      .out_ready   (sr_ready),
      .out_root    (sr_root),
      .out_side    (sr_side)
   );

   // ------------------------------------------------------------------
   // Middle stages: numerators p0*L + i*d*256, sign and magnitude
   // ------------------------------------------------------------------
   logic [2:0]              mb_vld_ff;
   logic [3:0]              mb_rdy;
   logic                    dv_ready;
   logic signed [33:0]      m0_plx_ff, m0_ply_ff;
   logic signed [26:0]      m0_pdx_ff, m0_pdy_ff;
   logic [ROOT_W-1:0]       m0_len_ff, m1_len_ff, m2_len_ff;
   post_type                m0_post_ff, m1_post_ff, m2_post_ff;
   logic signed [NUM_W-1:0] m1_numx_ff, m1_numy_ff;
   logic [NUM_W-1:0]        m2_magx_ff, m2_magy_ff;
   post_type                sr_post;
   post_type                m1_post_sgn;

   always_comb begin
      mb_rdy[3] = dv_ready;
      for (int k = 2; k >= 0; k--) begin
         mb_rdy[k] = !mb_vld_ff[k] || mb_rdy[k+1];
      end
   end
   assign sr_ready = mb_rdy[0];

   always_comb begin
      sr_post.x1       = sr_side.x1;
      sr_post.y1       = sr_side.y1;
      sr_post.neg_x    = 1'b0;
      sr_post.neg_y    = 1'b0;
      sr_post.zero_len = (sr_root == '0);
      sr_post.valid    = ({sr_side.step, 8'd0} < sr_root);
      sr_post.color    = sr_side.color;
   end

   // Record the numerator signs beside the segment data.
   always_comb begin
      m1_post_sgn       = m1_post_ff;
      m1_post_sgn.neg_x = m1_numx_ff[NUM_W-1];
      m1_post_sgn.neg_y = m1_numy_ff[NUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_vld_ff <= '0;
      end else begin
         if (mb_rdy[0]) mb_vld_ff[0] <= sr_valid;
         if (mb_rdy[1]) mb_vld_ff[1] <= mb_vld_ff[0];
         if (mb_rdy[2]) mb_vld_ff[2] <= mb_vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (mb_rdy[0]) begin
         m0_plx_ff  <= 34'(sr_side.x1 * $signed({1'b0, sr_root}));
         m0_ply_ff  <= 34'(sr_side.y1 * $signed({1'b0, sr_root}));
         m0_pdx_ff  <= 27'(sr_side.dx * $signed({1'b0, sr_side.step}));
         m0_pdy_ff  <= 27'(sr_side.dy * $signed({1'b0, sr_side.step}));
         m0_len_ff  <= sr_root;
         m0_post_ff <= sr_post;
      end
      if (mb_rdy[1]) begin
         m1_numx_ff <= NUM_W'(m0_plx_ff) + (NUM_W'(m0_pdx_ff) <<< 8);
         m1_numy_ff <= NUM_W'(m0_ply_ff) + (NUM_W'(m0_pdy_ff) <<< 8);
         m1_len_ff  <= m0_len_ff;
         m1_post_ff <= m0_post_ff;
      end
      if (mb_rdy[2]) begin
         m2_magx_ff <= m1_numx_ff[NUM_W-1] ? NUM_W'(-m1_numx_ff) : m1_numx_ff;
         m2_magy_ff <= m1_numy_ff[NUM_W-1] ? NUM_W'(-m1_numy_ff) : m1_numy_ff;
         m2_len_ff  <= m1_len_ff;
         m2_post_ff <= m1_post_sgn;
      end
   end

   // ------------------------------------------------------------------
   // Division by the length (quotient is only meaningful on valid steps)
   // ------------------------------------------------------------------
   logic              dq_valid;
   logic              dq_ready;
   logic [QUO_W-1:0]  dq_x, dq_y;
   post_type          dq_post;

   lspa_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mb_vld_ff[2]),
      .in_ready   (dv_ready),
      .in_num_x   (m2_magx_ff),
      .in_num_y   (m2_magy_ff),
      .in_divisor (m2_len_ff),
      .in_side    (m2_post_ff),
      .out_valid  (dq_valid),
      .out_ready  (dq_ready),
      .out_quo_x  (dq_x),
      .out_quo_y  (dq_y),
      .out_side   (dq_post)
   );

   // ------------------------------------------------------------------
   // Back stages: screen position, address products, final address
   // ------------------------------------------------------------------
   logic [2:0]          bc_vld_ff;
   logic [3:0]          bc_rdy;
   logic signed [13:0]  pos_x, pos_y;
   logic signed [14:0]  scr_x, scr_y;
   logic [XW-1:0]       b0_px_ff;
   logic [YW-1:0]       b0_py_ff;
   logic                b0_we_ff, b1_we_ff, b2_we_ff;
   logic                b0_sv_ff, b1_sv_ff, b2_sv_ff;
   logic [31:0]         b0_col_ff, b1_col_ff, b2_col_ff;
   logic [31:0]         b1_row_ff, b1_col_off_ff;
   logic [31:0]         b2_addr_ff;
   logic                on_screen;

   always_comb begin
      bc_rdy[3] = rsp_tready;
      for (int k = 2; k >= 0; k--) begin
         bc_rdy[k] = !bc_vld_ff[k] || bc_rdy[k+1];
      end
   end
   assign dq_ready = bc_rdy[0];

   // Truncation toward zero: apply the numerator sign to the quotient.
   always_comb begin
      if (dq_post.zero_len) begin
         pos_x = 14'(dq_post.x1);
         pos_y = 14'(dq_post.y1);
      end else begin
         pos_x = dq_post.neg_x ? -$signed({1'b0, dq_x}) : $signed({1'b0, dq_x});
         pos_y = dq_post.neg_y ? -$signed({1'b0, dq_y}) : $signed({1'b0, dq_y});
      end
      scr_x     = 15'(pos_x) + HALF_W;
      scr_y     = 15'(pos_y) + HALF_H;
      on_screen = (scr_x >= 0) && (scr_x < LIM_W) && (scr_y >= 0) && (scr_y < LIM_H);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_vld_ff <= '0;
      end else begin
         if (bc_rdy[0]) bc_vld_ff[0] <= dq_valid;
         if (bc_rdy[1]) bc_vld_ff[1] <= bc_vld_ff[0];
         if (bc_rdy[2]) bc_vld_ff[2] <= bc_vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (bc_rdy[0]) begin
         b0_px_ff  <= scr_x[XW-1:0];
         b0_py_ff  <= scr_y[YW-1:0];
         b0_sv_ff  <= dq_post.valid;
         b0_we_ff  <= dq_post.valid && on_screen;
         b0_col_ff <= dq_post.color;
      end
      if (bc_rdy[1]) begin
         b1_row_ff     <= 32'(b0_py_ff * bpr_ff);
         b1_col_off_ff <= 32'(b0_px_ff * bpp_ff);
         b1_sv_ff      <= b0_sv_ff;
         b1_we_ff      <= b0_we_ff;
         b1_col_ff     <= b0_col_ff;
      end
      if (bc_rdy[2]) begin
         b2_addr_ff <= b1_we_ff ? base_ff + b1_row_ff + b1_col_off_ff : 32'd0;
         b2_sv_ff   <= b1_sv_ff;
         b2_we_ff   <= b1_we_ff;
         b2_col_ff  <= b1_col_ff;
      end
   end

   assign rsp_tvalid = bc_vld_ff[2];
   assign rsp_tdata  = {b2_col_ff, b2_addr_ff};
   assign rsp_tuser  = {b2_we_ff, b2_sv_ff};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_we_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser[1] || rsp_tuser[0]))
      else $error("write enable without a valid step");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("nonzero address on a pixel that is not written");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (fa_vld_ff == '0) |-> req_tready)
      else $error("empty front stages refuse a transaction");

   a_zero_len_invalid: assert property (@(posedge clock) disable iff (reset)
      (dq_valid && dq_post.zero_len) |-> !dq_post.valid)
      else $error("zero-length segment marked as a valid step");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Line step pixel address core: testbench
// Streams line segments with step indexes into the core, predicts each pixel's
// address, color and flags, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lspa_pkg::*;

   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 1024;
   localparam int LATENCY       = 43;

   // Register index past the end of the map; writes to it are ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] color;
      logic        step_valid;
      logic        write_enable;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor copy of the registers.
   logic [31:0] frame_base_q;
   logic [14:0] row_stride_q;
   logic [3:0]  pixel_stride_q;

   logic [95:0] segment_queue[$];
   pixel_type   pixel_queue[$];
   int          error_count;
   int          pixels_checked;
   int          pixels_written;
   int          hold_cycles;
   int          gap_cycles;
   logic        hold_request;

   line_step_pixel_address_core #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("line_step_pixel_address_core test failed");
      $finish;
   end

   // Integer square root of a 64-bit value, bit by bit.
   function automatic longint unsigned root_of(longint unsigned value);
      longint unsigned root;
      longint unsigned bit_mask;
      root = 0;
      bit_mask = 64'd1 << 62;
      while (bit_mask > value) bit_mask >>= 2;
      while (bit_mask != 0) begin
         if (value >= root + bit_mask) begin
            value -= root + bit_mask;
            root = (root >> 1) + bit_mask;
         end else begin
            root >>= 1;
         end
         bit_mask >>= 2;
      end
      return root;
   endfunction

   // Expected pixel for one segment and step; division truncates toward zero.
   function automatic pixel_type pixel_for(logic [95:0] segment);
      pixel_type       pix;
      longint          x1, y1, x2, y2, dx, dy, step, length_fx, x, y, px, py;
      logic            on_screen;
      x1 = longint'($signed(segment[11:0]));
      y1 = longint'($signed(segment[23:12]));
      x2 = longint'($signed(segment[35:24]));
      y2 = longint'($signed(segment[47:36]));
      step = longint'(segment[92:80]);
      dx = x2 - x1;
      dy = y2 - y1;
      length_fx = longint'(root_of(longint'(dx * dx + dy * dy) << 16));
      x = x1;
      y = y1;
      if (length_fx > 0) begin
         x = (x1 * length_fx + step * dx * 256) / length_fx;
         y = (y1 * length_fx + step * dy * 256) / length_fx;
      end
      px = x + SCREEN_WIDTH / 2;
      py = y + SCREEN_HEIGHT / 2;
      on_screen = px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT;
      pix.step_valid = (step << 8) < length_fx;
      pix.write_enable = pix.step_valid && on_screen;
      pix.color = segment[79:48];
      pix.address = pix.write_enable ?
         frame_base_q + 32'(py) * 32'(row_stride_q) + 32'(px) * 32'(pixel_stride_q) : 32'd0;
      return pix;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: pops pending segments and offers them with random gaps, a few long.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         gap_cycles <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) pixel_queue.push_back(pixel_for(req_tdata));
         if (gap_cycles > 0) begin
            gap_cycles <= gap_cycles - 1;
            req_tvalid <= 1'b0;
         end else if (segment_queue.size() != 0 && ($urandom_range(0, 3) != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata <= segment_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
            if ($urandom_range(0, 30) == 0) gap_cycles <= $urandom_range(20, 80);
         end
      end
   end

   // Monitor: checks each accepted result transaction against the oldest expectation.
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 32'd0);
            end else begin
               want = pixel_queue.pop_front();
               pixels_checked++;
               if (want.write_enable) pixels_written++;
               if (rsp_tdata[31:0] !== want.address)
                  report_mismatch("byte_address", rsp_tdata[31:0], want.address);
               if (rsp_tdata[63:32] !== want.color)
                  report_mismatch("pixel_color", rsp_tdata[63:32], want.color);
               if (rsp_tuser[0] !== want.step_valid)
                  report_mismatch("step_valid", 32'(rsp_tuser[0]), 32'(want.step_valid));
               if (rsp_tuser[1] !== want.write_enable)
                  report_mismatch("write_enable", 32'(rsp_tuser[1]),
                                  32'(want.write_enable));
            end
         end
         // Long hold-off stretch on request, otherwise short random stalls.
         if (hold_request) begin
            hold_cycles <= 300;
            rsp_tready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 40) == 0) begin
            hold_cycles <= $urandom_range(5, 30);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 4) != 0);
         end
      end
   end

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_FRAME_BASE:      frame_base_q = value;
         REG_BYTES_PER_ROW:   row_stride_q = value[14:0];
         REG_BYTES_PER_PIXEL: pixel_stride_q = value[3:0];
         default: ;
      endcase
   endtask

   function automatic logic [95:0] segment_of(int sx, int sy, int ex, int ey,
                                              logic [31:0] color, int step);
      return {3'b000, 13'(step), color, 12'(ey), 12'(ex), 12'(sy), 12'(sx)};
   endfunction

   // Random segment: mostly steps within the line, on or near the screen.
   function automatic logic [95:0] random_segment();
      int sx, sy, ex, ey, step, reach;
      reach = ($urandom_range(0, 4) == 0) ? 2047 : 600;
      sx = $urandom_range(0, 2 * reach) - reach;
      sy = $urandom_range(0, 2 * reach) - reach;
      ex = $urandom_range(0, 2 * reach) - reach;
      ey = $urandom_range(0, 2 * reach) - reach;
      if ($urandom_range(0, 9) == 0) ex = sx;
      if ($urandom_range(0, 9) == 0) ey = sy;
      case ($urandom_range(0, 9))
         0: step = $urandom_range(0, 8191);
         1: step = 0;
         default: step = $urandom_range(0, 1200);
      endcase
      return segment_of(sx, sy, ex, ey, $urandom(), step);
   endfunction

   task automatic drain();
      while (segment_queue.size() != 0 || req_tvalid || pixel_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Stimulus: directed corners, then random phases under several settings.
   initial begin
      error_count = 0;
      pixels_checked = 0;
      pixels_written = 0;
      hold_cycles = 0;
      hold_request = 1'b0;
      frame_base_q = 32'd0;
      row_stride_q = BPR_RESET;
      pixel_stride_q = BPP_RESET;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero length, edges, extreme fields, index beyond the line.
      segment_queue.push_back(segment_of(0, 0, 0, 0, 32'hFFFF_FFFF, 0));
      segment_queue.push_back(segment_of(-2048, -2048, 2047, 2047, 32'h0, 8191));
      segment_queue.push_back(segment_of(-2048, -2048, 2047, 2047, 32'hA5A5_5A5A, 1));
      segment_queue.push_back(segment_of(2047, 2047, -2048, -2048, 32'h1234_5678, 5000));
      segment_queue.push_back(segment_of(-512, -512, -512, -512, 32'h1, 0));
      segment_queue.push_back(segment_of(511, 511, 511, 0, 32'h2, 0));
      segment_queue.push_back(segment_of(512, 0, 600, 0, 32'h3, 0));
      segment_queue.push_back(segment_of(0, 512, 0, 600, 32'h4, 0));
      segment_queue.push_back(segment_of(-513, 0, -600, 0, 32'h5, 0));
      segment_queue.push_back(segment_of(500, 0, 520, 0, 32'h6, 11));
      segment_queue.push_back(segment_of(500, 0, 520, 0, 32'h7, 12));
      segment_queue.push_back(segment_of(0, 0, 3, 4, 32'h8, 4));
      segment_queue.push_back(segment_of(0, 0, 3, 4, 32'h9, 5));
      segment_queue.push_back(segment_of(-5, 7, -9, -2, 32'hA, 3));
      segment_queue.push_back(segment_of(10, 10, 10, 10, 32'hB, 1));
      segment_queue.push_back(segment_of(-1, -1, 1, 1, 32'hC, 2));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(REG_FRAME_BASE, 32'hFFFF_FFF0);
               write_register(REG_BYTES_PER_ROW, 32'd16384);
               write_register(REG_BYTES_PER_PIXEL, 32'd8);
            end
            1: begin
               write_register(REG_FRAME_BASE, 32'h1000_0000);
               write_register(REG_BYTES_PER_ROW, 32'd1);
               write_register(REG_BYTES_PER_PIXEL, 32'd1);
            end
            2: begin
               write_register(REG_FRAME_BASE, $urandom());
               write_register(REG_BYTES_PER_ROW, 32'hFFFF_FFFF);
               write_register(REG_BYTES_PER_PIXEL, 32'hFFFF_FFFF);
            end
            3: begin
               write_register(REG_BYTES_PER_ROW, 32'd0);
               write_register(REG_BYTES_PER_PIXEL, 32'd0);
               write_register(REG_UNUSED, 32'hDEAD_BEEF);
            end
            default: begin
               write_register(REG_FRAME_BASE, $urandom());
               write_register(REG_BYTES_PER_ROW, $urandom_range(1, 16384));
               write_register(REG_BYTES_PER_PIXEL, $urandom_range(1, 8));
            end
         endcase
         for (int n = 0; n < 100; n++) segment_queue.push_back(random_segment());
         // Hold the receiver off while the sender keeps offering.
         if (phase == 1) begin
            hold_request <= 1'b1;
            @(posedge clock);
            hold_request <= 1'b0;
         end
         drain();
      end

      $display("Checked %0d pixel results (%0d written) across 7 register settings,",
               pixels_checked, pixels_written);
      $display("including zero-length lines, screen edges and out-of-range strides.");
      if (error_count == 0) begin
         $display("line_step_pixel_address_core test passed");
      end else begin
         $display("line_step_pixel_address_core test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/lspa_pkg.sv
hdl/lspa_isqrt.sv
hdl/lspa_divider.sv
hdl/line_step_pixel_address_core.sv
tb/testbench.sv
